// ===== design/mccp_pkg.sv =====
`default_nettype none

package mccp_pkg;

    // Configuration map: register index = paddr[4:2]
    localparam int unsigned ADDR_W = 5;
    localparam logic [2:0] REG_SPOT     = 3'd0;
    localparam logic [2:0] REG_STRIKE   = 3'd1;
    localparam logic [2:0] REG_DRIFT    = 3'd2;
    localparam logic [2:0] REG_VOL      = 3'd3;
    localparam logic [2:0] REG_DISCOUNT = 3'd4;

    // log2(e) and ln(2) in Q2.30
    localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;
    localparam logic [31:0]        LN2_Q30   = 32'd744261118;

    localparam int unsigned QUEUE_DEPTH = 4;

    typedef struct packed {
        logic signed [15:0] gaussian_sample;
        logic               last_path;
    } t_in;

    typedef struct packed {
        logic [31:0] option_price;
        logic [31:0] paths_used;
        logic        saturated;
    } t_out;

    // One priced path handed from the front to the back
    typedef struct packed {
        logic [31:0] payoff;
        logic        sat;
        logic        last;
    } t_path_rec;

    typedef enum logic [3:0] {
        F_IDLE,
        F_EXPO,
        F_LOG,
        F_SPLIT,
        F_ROM,
        F_INTERP,
        F_SUM,
        F_SCALE,
        F_SHIFT,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV,
        B_ROUND,
        B_MUL,
        B_PRICE
    } t_back_state;

endpackage

`default_nettype wire

// ===== design/mccp_queue.sv =====
`default_nettype none

module mccp_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire mccp_pkg::t_path_rec i_data,
    output logic                     o_full,
    input  wire logic                i_pop,
    output mccp_pkg::t_path_rec      o_data,
    output logic                     o_empty
);

    localparam int unsigned PTR_W = $clog2(mccp_pkg::QUEUE_DEPTH);

    mccp_pkg::t_path_rec r_mem [mccp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == (PTR_W+1)'(mccp_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/mccp_front.sv =====
`default_nettype none

module mccp_front #(
    parameter int unsigned EXP_TABLE_DEPTH = 1024
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire mccp_pkg::t_in       i_item,
    output logic                     o_busy,
    input  wire logic [31:0]         i_spot_price,
    input  wire logic [31:0]         i_strike_price,
    input  wire logic signed [31:0]  i_drift_term,
    input  wire logic [30:0]         i_vol_sqrt_t,
    input  wire logic                i_q_full,
    output logic                     o_q_push,
    output mccp_pkg::t_path_rec      o_q_data
);

    localparam int unsigned IDX_W = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int unsigned POS_W = 24 + IDX_W;
    localparam logic signed [47:0] LIM = 48'sh0400_0000_0000;

    typedef logic [31:0] t_rom [0:EXP_TABLE_DEPTH];

    // 2^(i/D) in Q2.30 from a rounded integer Taylor series of exp(i*ln2/D)
    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] a;
        logic [63:0] term;
        logic [63:0] acc;
        for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
            a    = (64'(i) * 64'(mccp_pkg::LN2_Q30) + 64'(EXP_TABLE_DEPTH / 2))
                   / 64'(EXP_TABLE_DEPTH);
            term = 64'd1 << 30;
            acc  = term;
            for (int k = 1; k <= 24; k++) begin
                if (term != 0) begin
                    term = (((term * a + (64'd1 << 29)) >> 30) + 64'(k / 2)) / 64'(k);
                    acc  = acc + term;
                end
            end
            rom[i] = acc[31:0];
        end
        return rom;
    endfunction

    localparam t_rom EXP_ROM = build_rom();

    mccp_pkg::t_front_state r_state, n_state;

    logic signed [15:0] r_z;
    logic               r_last;
    logic signed [47:0] r_x36;
    logic signed [63:0] r_y;
    logic signed [9:0]  r_n;
    logic [POS_W-1:0]   r_pos;
    logic [31:0]        r_lo;
    logic [31:0]        r_hi;
    logic [55:0]        r_prod;
    logic [31:0]        r_v;
    logic [63:0]        r_p;
    mccp_pkg::t_path_rec r_rec;

    logic signed [47:0] drift_ext;
    logic signed [47:0] vol_z;
    logic signed [47:0] x_clamped;
    logic [47:0]        x_biased;
    logic signed [31:0] x24;
    logic [63:0]        y_biased;
    logic [33:0]        uy24;
    logic [IDX_W-1:0]   idx;
    logic [31:0]        diff;
    logic [32:0]        v_sum;
    logic signed [9:0]  sh;
    logic [6:0]         sh_r;
    logic [63:0]        p_rnd;
    logic [63:0]        p_shr;
    logic [31:0]        st;
    logic               st_sat;

    assign o_busy   = (r_state != mccp_pkg::F_IDLE);
    assign o_q_data = r_rec;
    assign idx      = r_pos[24 +: IDX_W];

    always_comb begin
        drift_ext = 48'($signed({i_drift_term, 12'd0}));
        vol_z     = $signed({1'b0, i_vol_sqrt_t}) * r_z;
        if (r_x36 < -LIM) begin
            x_clamped = -LIM;
        end else if (r_x36 > LIM - 48'sd1) begin
            x_clamped = LIM - 48'sd1;
        end else begin
            x_clamped = r_x36;
        end
        x_biased = 48'(x_clamped + LIM + 48'sd2048);
        x24      = $signed(x_biased[43:12] - 32'h4000_0000);
        y_biased = 64'(r_y) + (64'd1 << 62) + (64'd1 << 29);
        uy24     = y_biased[63:30];
        diff     = (r_hi > r_lo) ? (r_hi - r_lo) : 32'd0;
        v_sum    = 33'(r_lo) + 33'((r_prod + 56'd8388608) >> 24);
    end

    // Scale by 2^(n-30) with round-to-nearest and saturation at 32 bits
    always_comb begin
        sh     = r_n - 10'sd30;
        sh_r   = 7'(-sh);
        p_rnd  = '0;
        p_shr  = '0;
        st     = '0;
        st_sat = 1'b0;
        if (r_p == '0) begin
            st = '0;
        end else if (!sh[9]) begin
            if (sh >= 10'sd32) begin
                st_sat = 1'b1;
            end else if ((r_p >> (7'd32 - 7'(sh))) != '0) begin
                st_sat = 1'b1;
            end else begin
                st = 32'(r_p << sh[4:0]);
            end
        end else if (sh_r < 7'd64) begin
            p_rnd = r_p + (64'd1 << (sh_r - 7'd1));
            p_shr = p_rnd >> sh_r;
            if (p_shr > 64'h0000_0000_FFFF_FFFF) begin
                st_sat = 1'b1;
            end else begin
                st = p_shr[31:0];
            end
        end
        if (st_sat) begin
            st = 32'hFFFF_FFFF;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            mccp_pkg::F_IDLE: begin
                r_z    <= i_item.gaussian_sample;
                r_last <= i_item.last_path;
            end
            mccp_pkg::F_EXPO:   r_x36 <= drift_ext + vol_z;
            mccp_pkg::F_LOG:    r_y   <= x24 * mccp_pkg::LOG2E_Q30;
            mccp_pkg::F_SPLIT: begin
                r_n   <= $signed(uy24[33:24]) - 10'sd256;
                r_pos <= POS_W'(uy24[23:0]) * POS_W'(EXP_TABLE_DEPTH);
            end
            mccp_pkg::F_ROM: begin
                r_lo <= EXP_ROM[idx];
                r_hi <= EXP_ROM[idx + 1'b1];
            end
            mccp_pkg::F_INTERP: r_prod <= diff * r_pos[23:0];
            mccp_pkg::F_SUM:    r_v    <= v_sum[31:0];
            mccp_pkg::F_SCALE:  r_p    <= 64'(i_spot_price) * 64'(r_v);
            mccp_pkg::F_SHIFT: begin
                r_rec.payoff <= (st > i_strike_price) ? (st - i_strike_price) : 32'd0;
                r_rec.sat    <= st_sat;
                r_rec.last   <= r_last;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mccp_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_q_push = 1'b0;
        unique case (r_state)
            mccp_pkg::F_IDLE:   if (i_push) n_state = mccp_pkg::F_EXPO;
            mccp_pkg::F_EXPO:   n_state = mccp_pkg::F_LOG;
            mccp_pkg::F_LOG:    n_state = mccp_pkg::F_SPLIT;
            mccp_pkg::F_SPLIT:  n_state = mccp_pkg::F_ROM;
            mccp_pkg::F_ROM:    n_state = mccp_pkg::F_INTERP;
            mccp_pkg::F_INTERP: n_state = mccp_pkg::F_SUM;
            mccp_pkg::F_SUM:    n_state = mccp_pkg::F_SCALE;
            mccp_pkg::F_SCALE:  n_state = mccp_pkg::F_SHIFT;
            mccp_pkg::F_SHIFT:  n_state = mccp_pkg::F_PUSH;
            mccp_pkg::F_PUSH: begin
                if (!i_q_full) begin
                    o_q_push = 1'b1;
                    n_state  = mccp_pkg::F_IDLE;
                end
            end
            default: n_state = mccp_pkg::F_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/mccp_back.sv =====
`default_nettype none

module mccp_back #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire mccp_pkg::t_path_rec i_q_data,
    input  wire logic                i_q_empty,
    output logic                     o_q_pop,
    input  wire logic [31:0]         i_discount_factor,
    output logic                     o_valid,
    input  wire logic                i_taken,
    output mccp_pkg::t_out           o_result
);

    localparam int unsigned CW = COUNT_WIDTH;

    mccp_pkg::t_back_state r_state, n_state;

    logic [63:0]   r_sum;
    logic [CW-1:0] r_count;
    logic          r_sat_seen;
    logic [CW-1:0] r_rem;
    logic [5:0]    r_step;
    logic [63:0]   r_mean;
    logic [63:0]   r_hi_part;
    logic [63:0]   r_lo_prod;
    logic          r_out_valid;
    mccp_pkg::t_out r_out;

    logic [64:0]   sum_add;
    logic          sum_ovf;
    logic          cnt_ovf;
    logic [63:0]   sum_next;
    logic [CW-1:0] cnt_next;
    logic [CW:0]   rem_sh;
    logic          q_bit;
    logic          round_up;
    logic [63:0]   lo_part;
    logic [64:0]   price_sum;
    logic          price_ovf;
    logic [40:0]   cnt_wide;
    logic [31:0]   paths;

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        sum_add   = 65'(r_sum) + 65'(i_q_data.payoff);
        sum_ovf   = sum_add[64];
        sum_next  = sum_ovf ? '1 : sum_add[63:0];
        cnt_ovf   = (r_count == '1);
        cnt_next  = cnt_ovf ? r_count : r_count + 1'b1;
        rem_sh    = {r_rem, r_sum[63]};
        q_bit     = (rem_sh >= {1'b0, r_count});
        round_up  = ({r_rem, 1'b0} >= {1'b0, r_count});
        lo_part   = (r_lo_prod + 64'h0000_0000_8000_0000) >> 32;
        price_sum = 65'(r_hi_part) + 65'(lo_part);
        price_ovf = (r_hi_part > 64'h0000_0000_FFFF_FFFF)
                    || (price_sum > 65'hFFFF_FFFF);
        cnt_wide  = 41'(r_count);
        paths     = (cnt_wide > 41'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : cnt_wide[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mccp_pkg::B_IDLE;
            r_sum       <= '0;
            r_count     <= '0;
            r_sat_seen  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_taken) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                mccp_pkg::B_IDLE: begin
                    if (!i_q_empty) begin
                        r_sum      <= sum_next;
                        r_count    <= cnt_next;
                        r_sat_seen <= r_sat_seen | i_q_data.sat | sum_ovf | cnt_ovf;
                    end
                end
                mccp_pkg::B_DIV: begin
                    r_sum <= {r_sum[62:0], q_bit};
                end
                mccp_pkg::B_PRICE: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_sum       <= '0;
                        r_count     <= '0;
                        r_sat_seen  <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath without reset: divider remainder, mean, products, result beat
    always_ff @(posedge i_clk) begin
        case (r_state)
            mccp_pkg::B_IDLE: begin
                r_rem  <= '0;
                r_step <= '0;
            end
            mccp_pkg::B_DIV: begin
                r_rem  <= q_bit ? CW'(rem_sh - {1'b0, r_count}) : rem_sh[CW-1:0];
                r_step <= r_step + 1'b1;
            end
            mccp_pkg::B_ROUND: begin
                r_mean <= (round_up && r_sum != '1) ? r_sum + 64'd1 : r_sum;
            end
            mccp_pkg::B_MUL: begin
                r_hi_part <= 64'(r_mean[63:32]) * 64'(i_discount_factor);
                r_lo_prod <= 64'(r_mean[31:0]) * 64'(i_discount_factor);
            end
            mccp_pkg::B_PRICE: begin
                if (!r_out_valid) begin
                    r_out.option_price <= price_ovf ? 32'hFFFF_FFFF : price_sum[31:0];
                    r_out.paths_used   <= paths;
                    r_out.saturated    <= r_sat_seen | price_ovf;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        unique case (r_state)
            mccp_pkg::B_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    if (i_q_data.last) begin
                        n_state = mccp_pkg::B_DIV;
                    end
                end
            end
            mccp_pkg::B_DIV:   if (r_step == '1) n_state = mccp_pkg::B_ROUND;
            mccp_pkg::B_ROUND: n_state = mccp_pkg::B_MUL;
            mccp_pkg::B_MUL:   n_state = mccp_pkg::B_PRICE;
            mccp_pkg::B_PRICE: if (!r_out_valid) n_state = mccp_pkg::B_IDLE;
            default:           n_state = mccp_pkg::B_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/monte_carlo_call_pricer.sv =====
// Monte Carlo European call pricer: one normal draw in, one priced batch out.
// Input channel: drive push with a draw in i_in_item; the beat is taken when
// full is low. full stays high while the front computes a path and until it
// has pushed the path into the queue, so no new draw is taken before that;
// the front steps through the fixed-point exp datapath (exponent, log2
// scaling, table lookup, interpolation, spot scaling, shift) in turn.
// Each priced path goes through a 4-entry queue to the back, which adds it
// to the batch sum as it pops it.
// Result channel: on a draw marked last_path the back divides the sum by the
// path count (one quotient bit per cycle), rounds, and scales by the discount.
// The result waits in an output register while empty is low; pop takes it.
// If the receiver stalls, the back holds the next batch's end and the queue
// then fills, raising full; no beat is lost.
// Configuration: APB writes at byte address 4*index, pready always high;
// change registers only while the block is idle.
// Reset (i_rst_n low, synchronous) clears the registers, the sum, the count,
// the saturation flag, the path queue and the result valid flag.
`default_nettype none

module monte_carlo_call_pricer #(
    parameter int unsigned COUNT_WIDTH     = 32,
    parameter int unsigned EXP_TABLE_DEPTH = 1024
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire mccp_pkg::t_in               i_in_item,
    output logic                             empty,
    input  wire logic                        pop,
    output mccp_pkg::t_out                   o_result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mccp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    logic [31:0]        r_spot_price;
    logic [31:0]        r_strike_price;
    logic signed [31:0] r_drift_term;
    logic [30:0]        r_vol_sqrt_t;
    logic [31:0]        r_discount_factor;

    logic [2:0]          reg_idx;
    logic                cfg_wr;
    logic                front_busy;
    logic                q_push;
    logic                q_full;
    logic                q_pop;
    logic                q_empty;
    mccp_pkg::t_path_rec q_wr_data;
    mccp_pkg::t_path_rec q_rd_data;
    logic                out_valid;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign full    = front_busy;
    assign empty   = !out_valid;

    // Register file: write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spot_price      <= '0;
            r_strike_price    <= '0;
            r_drift_term      <= '0;
            r_vol_sqrt_t      <= '0;
            r_discount_factor <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                mccp_pkg::REG_SPOT:     r_spot_price      <= pwdata;
                mccp_pkg::REG_STRIKE:   r_strike_price    <= pwdata;
                mccp_pkg::REG_DRIFT:    r_drift_term      <= $signed(pwdata);
                mccp_pkg::REG_VOL:      r_vol_sqrt_t      <= pwdata[30:0];
                mccp_pkg::REG_DISCOUNT: r_discount_factor <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            mccp_pkg::REG_SPOT:     prdata = r_spot_price;
            mccp_pkg::REG_STRIKE:   prdata = r_strike_price;
            mccp_pkg::REG_DRIFT:    prdata = r_drift_term;
            mccp_pkg::REG_VOL:      prdata = {1'b0, r_vol_sqrt_t};
            mccp_pkg::REG_DISCOUNT: prdata = r_discount_factor;
            default:                prdata = '0;
        endcase
    end

    // Front: exp and payoff for one path
    mccp_front #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_item         (i_in_item),
        .o_busy         (front_busy),
        .i_spot_price   (r_spot_price),
        .i_strike_price (r_strike_price),
        .i_drift_term   (r_drift_term),
        .i_vol_sqrt_t   (r_vol_sqrt_t),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_data       (q_wr_data)
    );

    // Decouple front and back
    mccp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rd_data),
        .o_empty (q_empty)
    );

    // Back: accumulate, average, discount
    mccp_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_data          (q_rd_data),
        .i_q_empty         (q_empty),
        .o_q_pop           (q_pop),
        .i_discount_factor (r_discount_factor),
        .o_valid           (out_valid),
        .i_taken           (pop),
        .o_result          (o_result)
    );

endmodule

`default_nettype wire

// ===== dv/monte_carlo_call_pricer_tb.sv =====
`timescale 1ns / 100ps

module monte_carlo_call_pricer_tb;

    localparam int unsigned TABLE_DEPTH = 1024;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned SETTLE_CYCLES = 120;
    localparam int unsigned RANDOM_PHASES = 5;
    localparam int unsigned PHASE_ITEMS = 150;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        push = 1'b0;
    logic                        full;
    mccp_pkg::t_in               i_in_item = '0;
    logic                        empty;
    logic                        pop = 1'b0;
    mccp_pkg::t_out              o_result;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [mccp_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0]                 pwdata = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    monte_carlo_call_pricer DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_in_item(i_in_item),
        .empty(empty), .pop(pop), .o_result(o_result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // Pricer shadow state, kept in step with every accepted beat and register write.
    logic [31:0] spot_q, strike_q, drift_q, disc_q;
    logic [30:0] vol_q;
    bit   [63:0] sum_q;
    bit   [63:0] count_q;
    bit          sat_q;
    bit   [31:0] exp2_lut [0:TABLE_DEPTH];

    mccp_pkg::t_out pending_prices [$];
    int unsigned error_count = 0;
    bit          no_idle = 1'b0;
    bit          reset_done = 1'b0;
    int unsigned stall_cycles = 0;

    // 2^(i/D) in Q2.30 from a rounded Taylor series of exp(i*ln2/D).
    function automatic void build_exp2_lut();
        bit [63:0] a, term, acc;
        for (int i = 0; i <= TABLE_DEPTH; i++) begin
            a = (64'(i) * 64'(mccp_pkg::LN2_Q30) + TABLE_DEPTH / 2) / TABLE_DEPTH;
            term = 64'd1 << 30;
            acc = term;
            for (int k = 1; k <= 24 && term != 0; k++) begin
                term = (((term * a + (64'd1 << 29)) >> 30) + 64'(k / 2)) / 64'(k);
                acc += term;
            end
            exp2_lut[i] = acc[31:0];
        end
    endfunction

    // ST = spot * exp(drift + vol*Z), Q16.16, saturating.
    function automatic bit [31:0] terminal_price(input logic [15:0] z, inout bit sat);
        longint    x36, x24, y, u24;
        longint    lim;
        bit [63:0] uy24, f, pos, idx, frac, lo, hi, v, p;
        int        n, sh;
        lim = 64'sd1 <<< 42;
        x36 = longint'($signed(drift_q)) * 4096 + longint'(vol_q) * longint'($signed(z));
        if (x36 < -lim) x36 = -lim;
        if (x36 > lim - 1) x36 = lim - 1;
        u24 = (x36 + lim + 2048) >>> 12;
        x24 = u24 - (64'sd1 <<< 30);
        y = x24 * longint'(mccp_pkg::LOG2E_Q30);
        uy24 = 64'(y + (64'sd1 <<< 62) + (64'sd1 <<< 29)) >> 30;
        n = int'(uy24 >> 24) - 256;
        f = uy24 & 64'hFF_FFFF;
        pos = f * TABLE_DEPTH;
        idx = pos >> 24;
        frac = pos & 64'hFF_FFFF;
        lo = 64'(exp2_lut[idx]);
        hi = 64'(exp2_lut[idx + 1]);
        v = lo + ((hi > lo) ? (((hi - lo) * frac + (64'd1 << 23)) >> 24) : 64'd0);
        p = 64'(spot_q) * v;
        sh = n - 30;
        if (p == 0) return 32'd0;
        if (sh >= 0) begin
            if (sh >= 32 || p > (64'hFFFF_FFFF >> sh)) begin
                sat = 1'b1;
                return 32'hFFFF_FFFF;
            end
            return 32'(p << sh);
        end
        sh = -sh;
        if (sh >= 64) return 32'd0;
        p = (p + (64'd1 << (sh - 1))) >> sh;
        if (p > 64'hFFFF_FFFF) begin
            sat = 1'b1;
            return 32'hFFFF_FFFF;
        end
        return p[31:0];
    endfunction

    // Fold one path into the batch; queue the price when the path closes a batch.
    task automatic accumulate_path(input mccp_pkg::t_in beat);
        bit             sat;
        bit [31:0]      st, payoff;
        bit [63:0]      q, r, mean, hi_part, lo_part;
        mccp_pkg::t_out res;
        sat = 1'b0;
        st = terminal_price(beat.gaussian_sample, sat);
        payoff = (st > strike_q) ? st - strike_q : 32'd0;
        if (sum_q > 64'hFFFF_FFFF_FFFF_FFFF - 64'(payoff)) begin
            sum_q = '1;
            sat = 1'b1;
        end else begin
            sum_q += 64'(payoff);
        end
        if (count_q >= 64'hFFFF_FFFF) begin
            count_q = 64'hFFFF_FFFF;
            sat = 1'b1;
        end else begin
            count_q++;
        end
        if (sat) sat_q = 1'b1;
        if (!beat.last_path) return;
        q = sum_q / count_q;
        r = sum_q % count_q;
        mean = q + ((r >= count_q - r) ? 64'd1 : 64'd0);
        if (mean < q) mean = '1;
        hi_part = (mean >> 32) * 64'(disc_q);
        lo_part = ((mean & 64'hFFFF_FFFF) * 64'(disc_q) + (64'd1 << 31)) >> 32;
        if (hi_part > 64'hFFFF_FFFF || hi_part + lo_part > 64'hFFFF_FFFF) begin
            res.option_price = 32'hFFFF_FFFF;
            sat_q = 1'b1;
        end else begin
            res.option_price = 32'(hi_part + lo_part);
        end
        res.paths_used = count_q[31:0];
        res.saturated = sat_q;
        pending_prices.push_back(res);
        sum_q = 0;
        count_q = 0;
        sat_q = 1'b0;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR @%0t: %s got 0x%08h expected 0x%08h", $time, what, got, want);
        error_count++;
    endtask

    // Send one draw; hold push high on return so back-to-back beats stay seamless.
    task automatic send_path(input logic [15:0] z, input logic last);
        mccp_pkg::t_in beat;
        beat.gaussian_sample = z;
        beat.last_path = last;
        if (!no_idle && $urandom_range(99) < 35) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_in_item <= beat;
        do @(posedge i_clk); while (full);
        accumulate_path(beat);
    endtask

    task automatic stop_sending();
        push <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait out every pending price, then let the datapath settle.
    task automatic drain();
        while (pending_prices.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= mccp_pkg::ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            mccp_pkg::REG_SPOT:     spot_q = value;
            mccp_pkg::REG_STRIKE:   strike_q = value;
            mccp_pkg::REG_DRIFT:    drift_q = value;
            mccp_pkg::REG_VOL:      vol_q = value[30:0];
            mccp_pkg::REG_DISCOUNT: disc_q = value;
            default: ;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_market(input logic [31:0] s, input logic [31:0] k,
                              input logic [31:0] d, input logic [31:0] v,
                              input logic [31:0] disc);
        drain();
        write_reg(mccp_pkg::REG_SPOT, s);
        write_reg(mccp_pkg::REG_STRIKE, k);
        write_reg(mccp_pkg::REG_DRIFT, d);
        write_reg(mccp_pkg::REG_VOL, v);
        write_reg(mccp_pkg::REG_DISCOUNT, disc);
        @(posedge i_clk);
    endtask

    task automatic pick_market();
        logic [31:0] s, k, d;
        if ($urandom_range(3) == 0) begin
            set_market($urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            s = ($urandom_range(1, 400) << 16) | $urandom_range(0, 16'hFFFF);
            k = s + ($urandom_range(0, 60) << 16) - (32'd30 << 16);
            d = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
            set_market(s, k, d, $urandom_range(0, 32'h0100_0000),
                       32'hC000_0000 | $urandom);
        end
    endtask

    // Mostly bell-shaped draws, with a share drawn from the whole range.
    function automatic logic [15:0] draw_sample();
        if ($urandom_range(99) < 15) return 16'($urandom);
        return 16'($urandom_range(0, 8192) + $urandom_range(0, 8192)
                   + $urandom_range(0, 8192) - 12288);
    endfunction

    task automatic test_nominal_market();
        set_market(32'd100 << 16, 32'd100 << 16, 32'h0002_0000, 32'h0033_3333,
                   32'hF333_3333);
        send_path(16'h8000, 1'b0);
        send_path(16'h7FFF, 1'b0);
        send_path(16'h0000, 1'b1);
        send_path(16'h1000, 1'b1);
        send_path(16'hF000, 1'b0);
        send_path(16'h2000, 1'b1);
        stop_sending();
    endtask

    task automatic test_extreme_market();
        // Huge exponent saturates ST; huge negative one rounds ST down to zero.
        set_market(32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'hFFFF_FFFF);
        send_path(16'h7FFF, 1'b1);
        send_path(16'h8000, 1'b1);
        send_path(16'h7FFF, 1'b0);
        send_path(16'h0001, 1'b1);
        stop_sending();
        // Zero spot and zero discount.
        set_market(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                   32'h0000_0000);
        send_path(16'h7FFF, 1'b0);
        send_path(16'h0000, 1'b1);
        stop_sending();
        // Tiny strike, with the exponent pinned at its lower clamp so ST rounds to zero.
        set_market(32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000);
        send_path(16'h8000, 1'b0);
        send_path(16'h0000, 1'b1);
        stop_sending();
    endtask

    task automatic test_random_batches();
        int left;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            pick_market();
            no_idle = (ph == 2);
            left = $urandom_range(1, 24);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                left--;
                send_path(draw_sample(), (left == 0 || i == PHASE_ITEMS - 1));
                if (left == 0) left = $urandom_range(1, 24);
            end
            stop_sending();
            no_idle = 1'b0;
        end
    endtask

    task automatic test_pause_for_drain();
        pick_market();
        for (int i = 0; i < 8; i++) send_path(draw_sample(), (i % 4 == 3));
        // Hold the sender until the block has nothing left to deliver.
        push <= 1'b0;
        while (pending_prices.size() != 0) @(posedge i_clk);
        for (int i = 0; i < 6; i++) send_path(draw_sample(), (i == 5));
        stop_sending();
    endtask

    // Check each price beat against the oldest pending one; randomize pop.
    always @(posedge i_clk) begin
        mccp_pkg::t_out want;
        if (reset_done && pop && !empty) begin
            if (pending_prices.size() == 0) begin
                report_mismatch("unexpected price beat", o_result.option_price, 32'd0);
            end else begin
                want = pending_prices.pop_front();
                if (o_result.option_price !== want.option_price)
                    report_mismatch("option_price", o_result.option_price, want.option_price);
                if (o_result.paths_used !== want.paths_used)
                    report_mismatch("paths_used", o_result.paths_used, want.paths_used);
                if (o_result.saturated !== want.saturated)
                    report_mismatch("saturated", 32'(o_result.saturated),
                                    32'(want.saturated));
            end
        end
        pop <= no_idle ? 1'b1 : ($urandom_range(99) >= 35);
    end

    // Abort when no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if (reset_done) begin
            if ((push && !full) || (pop && !empty)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("monte_carlo_call_pricer: mismatch");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        spot_q = 0; strike_q = 0; drift_q = 0; vol_q = 0; disc_q = 0;
        sum_q = 0; count_q = 0; sat_q = 1'b0;
        build_exp2_lut();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        reset_done = 1'b1;
        test_nominal_market();
        test_extreme_market();
        test_random_batches();
        test_pause_for_drain();
        drain();
        if (error_count == 0) begin
            $display("monte_carlo_call_pricer: match");
        end else begin
            $display("monte_carlo_call_pricer: mismatch");
        end
        $finish;
    end

endmodule

// ===== monte_carlo_call_pricer.f =====
design/mccp_pkg.sv
design/mccp_queue.sv
design/mccp_front.sv
design/mccp_back.sv
design/monte_carlo_call_pricer.sv
dv/monte_carlo_call_pricer_tb.sv
